// ===== design/smr_pkg.sv =====
`default_nettype none

package smr_pkg;

   // Geometry of the frame buffer: two banks of SIDE_MAX x SIDE_MAX words.
   localparam int SIDE_MAX   = 8;
   localparam int IDX_W      = $clog2(SIDE_MAX);
   localparam int BANK_W     = 1;
   localparam int ADDR_W     = BANK_W + 2 * IDX_W;
   localparam int RAM_DEPTH  = 1 << ADDR_W;
   localparam int DATA_W     = 32;

   // Matrix-done queue: one entry per bank.
   localparam int TOK_DEPTH  = 1 << BANK_W;
   localparam int TOK_CNT_W  = BANK_W + 1;

   // Result buffer in the unload side.
   localparam int OUT_DEPTH  = 2;
   localparam int OUT_PTR_W  = 1;
   localparam int OUT_CNT_W  = 2;

   // Control registers.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int SIZE_W     = 4;
   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(SIDE_MAX);
   localparam logic [CSR_ADDR_W-3:0] REG_MATRIX_SIZE = '0;

   typedef struct packed {
      logic              bank;
      logic [IDX_W-1:0]  last_idx;   // n-1 of the stored matrix
   } token_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
   } ram_wr_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } ram_rd_type;

   // Register value to n-1, with 0 treated as 1 and anything above SIDE_MAX as SIDE_MAX.
   function automatic logic [IDX_W-1:0] last_index(input logic [SIZE_W-1:0] size);
      logic [SIZE_W-1:0] n;
      n = size;
      if (n == '0) begin
         n = SIZE_W'(1);
      end
      if (n > SIZE_W'(SIDE_MAX)) begin
         n = SIZE_W'(SIDE_MAX);
      end
      return IDX_W'(n - SIZE_W'(1));
   endfunction

endpackage

`default_nettype wire

// ===== design/smr_load.sv =====
`default_nettype none

module smr_load import smr_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   input  wire logic                  req_push,
   input  wire logic [DATA_W-1:0]     req_element_value,
   output logic                       req_full,
   output ram_wr_type                 ram_wr,
   output logic                       tok_push,
   output token_type                  tok_push_data,
   input  wire logic                  tok_full
);

   logic [SIZE_W-1:0] size_ff, size_in;
   logic [IDX_W-1:0]  row_ff, row_in;
   logic [IDX_W-1:0]  col_ff, col_in;
   logic              bank_ff, bank_in;
   logic [IDX_W-1:0]  last_idx;
   logic              reg_sel;
   logic              csr_wr;
   logic              accept;

   assign last_idx = last_index(size_ff);
   assign reg_sel  = (csr_paddr[CSR_ADDR_W-1:2] == REG_MATRIX_SIZE);
   assign csr_wr   = csr_psel && csr_penable && csr_pwrite && reg_sel;
   assign csr_prdata = reg_sel ? CSR_DATA_W'(size_ff) : '0;

   // Both banks hold unread matrices: hold off the loader.
   assign req_full = tok_full;
   assign accept   = req_push && !tok_full;

   assign ram_wr.en   = accept;
   assign ram_wr.addr = {bank_ff, row_ff, col_ff};
   assign ram_wr.data = req_element_value;

   assign tok_push               = accept && (col_ff == last_idx) && (row_ff == last_idx);
   assign tok_push_data.bank     = bank_ff;
   assign tok_push_data.last_idx = last_idx;

   always_comb begin
      size_in = size_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      bank_in = bank_ff;
      priority if (csr_wr) begin
         // new size drops any partly loaded matrix
         size_in = csr_pwdata[SIZE_W-1:0];
         row_in  = '0;
         col_in  = '0;
      end else if (accept) begin
         if (col_ff == last_idx) begin
            col_in = '0;
            if (row_ff == last_idx) begin
               row_in  = '0;
               bank_in = !bank_ff;
            end else begin
               row_in = row_ff + IDX_W'(1);
            end
         end else begin
            col_in = col_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
         row_ff  <= '0;
         col_ff  <= '0;
         bank_ff <= 1'b0;
      end else begin
         size_ff <= size_in;
         row_ff  <= row_in;
         col_ff  <= col_in;
         bank_ff <= bank_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/smr_token_fifo.sv =====
`default_nettype none

module smr_token_fifo import smr_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire token_type push_data,
   output logic           full,
   input  wire logic      pop,
   output logic           valid,
   output token_type      head
);

   token_type             entry_ff [TOK_DEPTH];
   logic [BANK_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [BANK_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [TOK_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                  do_push;
   logic                  do_pop;

   assign full    = (cnt_ff == TOK_CNT_W'(TOK_DEPTH));
   assign valid   = (cnt_ff != '0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + BANK_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + BANK_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + TOK_CNT_W'(do_push) - TOK_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== design/smr_frame_buf.sv =====
`default_nettype none

module smr_frame_buf import smr_pkg::*; (
   input  wire logic        clock,
   input  wire ram_wr_type  wr,
   input  wire ram_rd_type  rd,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [RAM_DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

endmodule

`default_nettype wire

// ===== design/smr_unload.sv =====
`default_nettype none

module smr_unload import smr_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               tok_valid,
   input  wire token_type          tok_head,
   output logic                    tok_pop,
   output ram_rd_type              ram_rd,
   input  wire logic [DATA_W-1:0]  rd_data,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output logic [DATA_W-1:0]       rsp_rotated_value,
   output logic                    rsp_last_of_matrix
);

   logic [IDX_W-1:0]     r_ff, r_in;
   logic [IDX_W-1:0]     c_ff, c_in;
   logic                 inflight_ff;
   logic                 inflight_last_ff;
   logic [DATA_W-1:0]    buf_data_ff [OUT_DEPTH];
   logic                 buf_last_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [OUT_CNT_W-1:0] cnt_ff, cnt_in;
   logic [OUT_CNT_W:0]   pending;
   logic                 fire;
   logic                 issue;
   logic                 last_issue;
   logic [IDX_W-1:0]     src_row;

   assign rsp_empty          = (cnt_ff == '0);
   assign rsp_rotated_value  = buf_data_ff[rd_ptr_ff];
   assign rsp_last_of_matrix = buf_last_ff[rd_ptr_ff];
   assign fire               = rsp_pop && !rsp_empty;

   // reads in flight plus buffered results never exceed the buffer
   assign pending = (OUT_CNT_W+1)'(cnt_ff) + (OUT_CNT_W+1)'(inflight_ff);
   assign issue   = tok_valid && ((pending < (OUT_CNT_W+1)'(OUT_DEPTH)) || fire);

   // out(r,c) = in(n-1-c, r)
   assign src_row     = tok_head.last_idx - c_ff;
   assign ram_rd.en   = issue;
   assign ram_rd.addr = {tok_head.bank, src_row, r_ff};

   assign last_issue = (r_ff == tok_head.last_idx) && (c_ff == tok_head.last_idx);
   assign tok_pop    = issue && last_issue;   // bank freed once last word is read

   always_comb begin
      r_in = r_ff;
      c_in = c_ff;
      if (issue) begin
         if (c_ff == tok_head.last_idx) begin
            c_in = '0;
            r_in = last_issue ? '0 : r_ff + IDX_W'(1);
         end else begin
            c_in = c_ff + IDX_W'(1);
         end
      end
      cnt_in = cnt_ff + OUT_CNT_W'(inflight_ff) - OUT_CNT_W'(fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_ff        <= '0;
         c_ff        <= '0;
         inflight_ff <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         cnt_ff      <= '0;
      end else begin
         r_ff        <= r_in;
         c_ff        <= c_in;
         inflight_ff <= issue;
         if (inflight_ff) begin
            wr_ptr_ff <= wr_ptr_ff + OUT_PTR_W'(1);
         end
         if (fire) begin
            rd_ptr_ff <= rd_ptr_ff + OUT_PTR_W'(1);
         end
         cnt_ff      <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         inflight_last_ff <= last_issue;
      end
      if (inflight_ff) begin
         buf_data_ff[wr_ptr_ff] <= rd_data;
         buf_last_ff[wr_ptr_ff] <= inflight_last_ff;
      end
   end

endmodule

`default_nettype wire

// ===== design/square_matrix_rotate_cw.sv =====
`default_nettype none

// Channel   Ports                                    Transfer when
// --------  ---------------------------------------  ----------------------------------
// request   req_push, req_full, req_element_value    req_push && !req_full
// response  rsp_pop, rsp_empty, rsp_rotated_value,   rsp_pop && !rsp_empty
//           rsp_last_of_matrix
// control   csr_psel/penable/pwrite/paddr/pwdata,    psel && penable && pwrite (pready=1)
//           csr_prdata, csr_pready
//
// The loader takes a new element whenever req_full is low. The unloader reads the frame
// buffer one word per cycle through its single read port while a matrix is queued and
// the result buffer has room; each word goes out via the read register and the buffer.
// The frame buffer has two banks, so the next matrix loads while the previous one drains;
// req_full rises only while both banks hold matrices not yet fully read out.
// Reset clears counters and queues and presets the size; buffer is never read before written.
module square_matrix_rotate_cw import smr_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // control registers
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   // element input
   input  wire logic                  req_push,
   input  wire logic [DATA_W-1:0]     req_element_value,
   output logic                       req_full,
   // rotated output
   output logic                       rsp_empty,
   input  wire logic                  rsp_pop,
   output logic [DATA_W-1:0]          rsp_rotated_value,
   output logic                       rsp_last_of_matrix
);

   ram_wr_type        ram_wr;
   ram_rd_type        ram_rd;
   logic [DATA_W-1:0] rd_data;
   logic              tok_push;
   token_type         tok_push_data;
   logic              tok_full;
   logic              tok_pop;
   logic              tok_valid;
   token_type         tok_head;

   // No wait states on the control port.
   assign csr_pready = 1'b1;

   // Front: size register, load position, bank select; posts a token per full matrix.
   smr_load u_load (
      .clock             (clock),
      .reset             (reset),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .req_push          (req_push),
      .req_element_value (req_element_value),
      .req_full          (req_full),
      .ram_wr            (ram_wr),
      .tok_push          (tok_push),
      .tok_push_data     (tok_push_data),
      .tok_full          (tok_full)
   );

   // Queue of loaded matrices, one slot per bank; count equals banks in use.
   smr_token_fifo u_tok_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (tok_push),
      .push_data (tok_push_data),
      .full      (tok_full),
      .pop       (tok_pop),
      .valid     (tok_valid),
      .head      (tok_head)
   );

   // Two-bank frame buffer: one write port, one registered read port.
   smr_frame_buf u_frame_buf (
      .clock   (clock),
      .wr      (ram_wr),
      .rd      (ram_rd),
      .rd_data (rd_data)
   );

   // Back: walks the rotated order, reads the buffer, holds results for the consumer.
   smr_unload u_unload (
      .clock              (clock),
      .reset              (reset),
      .tok_valid          (tok_valid),
      .tok_head           (tok_head),
      .tok_pop            (tok_pop),
      .ram_rd             (ram_rd),
      .rd_data            (rd_data),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_rotated_value  (rsp_rotated_value),
      .rsp_last_of_matrix (rsp_last_of_matrix)
   );

endmodule

`default_nettype wire
